// ----- rtl/core/jpd_pkg.sv -----
package jpd_pkg;

  // Number of analogue channels that the default build decodes.
  localparam int NUM_AXES_DEF = 7;

  // Header channel code that carries the two buttons.
  localparam logic [2:0] BTN_CHAN = 3'd7;

  // Reading, reciprocal and product widths of the scaling path.
  localparam int READ_W      = 10;
  localparam int RECIP_W     = 28;
  localparam int PROD_W      = READ_W + RECIP_W;
  localparam int RECIP_SHIFT = 20;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int VALUE_W     = 16;

  // Clamp limit: one half in Q1.15.
  localparam int Q_HALF = 16384;

  // Depth of the result queue in front of the output port.
  localparam int FIFO_DEPTH = 8;

  typedef enum logic [1:0] {
    KIND_ANALOG   = 2'd0,
    KIND_BASELINE = 2'd1,
    KIND_BUTTONS  = 2'd2
  } kind_t;

  // Per-word control that travels alongside the data through the pipeline.
  typedef struct packed {
    logic [2:0] chan;
    kind_t      kind;
    logic       left;
    logic       right;
  } tag_t;

  // One finished result word.
  typedef struct packed {
    tag_t                      tag;
    logic signed [VALUE_W-1:0] value;
  } res_t;

  // Reciprocal of each channel's full-scale span, rounded up: ceil(2^35 / scale).
  // With a 10-bit magnitude, (mag * recip) >> 20 equals floor(mag * 32768 / scale)
  // exactly, since the rounding error times the largest dividend stays below 2^35.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] chan);
    logic [RECIP_W-1:0] r;
    unique case (chan)
      3'd0:    r = 28'd33719076;   // scale 1019
      3'd1:    r = 28'd151364487;  // scale 227
      3'd2:    r = 28'd165191050;  // scale 208
      3'd3:    r = 28'd85899346;   // scale 400
      3'd4:    r = 28'd171798692;  // scale 200
      3'd5:    r = 28'd161313326;  // scale 213
      3'd6:    r = 28'd81421181;   // scale 422
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/jpd_scale.sv -----
module jpd_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_v,
  input  jpd_pkg::tag_t                       in_tag,
  input  logic [jpd_pkg::READ_W-1:0]          in_mag,
  input  logic                                in_neg,
  output logic                                out_v,
  output jpd_pkg::res_t                       out_res,
  output logic [1:0]                          busy
);

  logic                              a_v_r;
  jpd_pkg::tag_t                     a_tag_r;
  logic [jpd_pkg::READ_W-1:0]        a_mag_r;
  logic                              a_neg_r;
  logic [jpd_pkg::RECIP_W-1:0]       a_recip_r;

  logic                              b_v_r;
  jpd_pkg::tag_t                     b_tag_r;
  logic                              b_neg_r;
  logic [jpd_pkg::PROD_W-1:0]        b_prod_r;

  logic [jpd_pkg::QUOT_W-1:0]        quot;
  logic [jpd_pkg::VALUE_W-1:0]       mag_c;

  // Valid bits of the two stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
    end
  end

  // First stage: pick up the channel's reciprocal.
  always_ff @(posedge clk) begin
    a_tag_r   <= in_tag;
    a_mag_r   <= in_mag;
    a_neg_r   <= in_neg;
    a_recip_r <= jpd_pkg::recip_of(in_tag.chan);
  end

  // Second stage: one 10 by 28 multiply.
  always_ff @(posedge clk) begin
    b_tag_r  <= a_tag_r;
    b_neg_r  <= a_neg_r;
    b_prod_r <= jpd_pkg::PROD_W'(a_mag_r) * jpd_pkg::PROD_W'(a_recip_r);
  end

  // Quotient, clamp to one half, then restore the sign.
  always_comb begin
    quot = b_prod_r[jpd_pkg::RECIP_SHIFT +: jpd_pkg::QUOT_W];
    if (quot > jpd_pkg::QUOT_W'(jpd_pkg::Q_HALF)) begin
      mag_c = jpd_pkg::VALUE_W'(jpd_pkg::Q_HALF);
    end else begin
      mag_c = quot[jpd_pkg::VALUE_W-1:0];
    end
    out_res.tag   = b_tag_r;
    out_res.value = b_neg_r ? $signed(jpd_pkg::VALUE_W'(0) - mag_c) : $signed(mag_c);
  end

  assign out_v = b_v_r;
  assign busy  = {1'b0, a_v_r} + {1'b0, b_v_r};

endmodule

// ----- rtl/core/joystick_pair_decoder_unit.sv -----
// Channel  Direction  Handshake            Word
// in_      input      in_valid / in_stall   rx_byte: one serial byte
// out_     output     out_valid / out_stall chan_index, report_kind, axis_value, buttons
//
// A byte is taken every cycle while the result queue has room; a completed pair
// shows its result at the output after the baseline read at the accepting edge, the
// reciprocal fetch, the multiply and the queue write. The eight-entry result queue
// sets how far the output may fall behind: in_stall rises once queued and in-flight
// words fill it.
// Reset is synchronous and clears the held header, the baseline valid bits and the queue.
// The baseline memory needs no clearing; its entries are read only once written.
module joystick_pair_decoder_unit #(
  parameter int NUM_AXES = jpd_pkg::NUM_AXES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_chan_index,
  output logic [1:0]                          out_report_kind,
  output logic signed [jpd_pkg::VALUE_W-1:0]  out_axis_value,
  output logic                                out_left_button,
  output logic                                out_right_button
);

  localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int FW  = $clog2(jpd_pkg::FIFO_DEPTH);
  localparam int CW  = FW + 1;

  // Header and baseline bookkeeping.
  logic                           hdr_pending_r;
  logic [5:0]                     held_hdr_r;
  logic [NUM_AXES-1:0]            base_valid_r;
  logic [jpd_pkg::READ_W-1:0]     base_mem [NUM_AXES];
  logic [jpd_pkg::READ_W-1:0]     base_rd_r;

  logic                           acc;
  logic                           pair;
  logic                           is_btn;
  logic                           in_range;
  logic [2:0]                     d_ch;
  logic [AXW-1:0]                 ax_idx;
  logic [jpd_pkg::READ_W-1:0]     reading;
  logic                           cap;
  logic                           ana;
  logic                           s0_v;
  jpd_pkg::tag_t                  s0_tag;

  logic                           s1_v_r;
  jpd_pkg::tag_t                  s1_tag_r;
  logic [jpd_pkg::READ_W-1:0]     s1_read_r;
  logic [jpd_pkg::READ_W:0]       diff;
  logic [jpd_pkg::READ_W-1:0]     s1_mag;
  logic                           s1_neg;

  logic                           sc_v;
  jpd_pkg::res_t                  sc_res;
  logic [1:0]                     sc_busy;

  jpd_pkg::res_t                  fifo_mem [jpd_pkg::FIFO_DEPTH];
  logic [FW-1:0]                  wr_ptr_r;
  logic [FW-1:0]                  rd_ptr_r;
  logic [CW-1:0]                  fifo_cnt_r;
  logic [CW-1:0]                  occupancy;
  logic                           push;
  logic                           pop;
  jpd_pkg::res_t                  head;

  // Room check: every word in flight already has a queue slot reserved.
  assign occupancy = fifo_cnt_r + CW'({1'b0, s1_v_r}) + CW'(sc_busy);
  assign in_stall  = (occupancy >= CW'(jpd_pkg::FIFO_DEPTH));
  assign acc       = in_valid && !in_stall;

  // Decode of the accepted byte against the held header.
  always_comb begin
    d_ch     = held_hdr_r[5:3];
    ax_idx   = d_ch[AXW-1:0];
    reading  = {held_hdr_r[2:0], in_rx_byte[6:0]};
    pair     = acc && in_rx_byte[7] && hdr_pending_r;
    is_btn   = (d_ch == jpd_pkg::BTN_CHAN);
    in_range = (int'(d_ch) < NUM_AXES);
    cap      = pair && !is_btn && in_range && !base_valid_r[ax_idx];
    ana      = pair && !is_btn && in_range && base_valid_r[ax_idx];
    s0_v     = pair && (is_btn || in_range);
    s0_tag.chan  = d_ch;
    s0_tag.kind  = is_btn ? jpd_pkg::KIND_BUTTONS :
                   (cap ? jpd_pkg::KIND_BASELINE : jpd_pkg::KIND_ANALOG);
    s0_tag.left  = is_btn && !in_rx_byte[1];
    s0_tag.right = is_btn && !in_rx_byte[0];
  end

  // Header holding and baseline capture flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pending_r <= 1'b0;
      held_hdr_r    <= '0;
      base_valid_r  <= '0;
    end else if (acc) begin
      if (!in_rx_byte[7]) begin
        if (in_rx_byte[6]) begin
          hdr_pending_r <= 1'b0;
        end else begin
          held_hdr_r    <= in_rx_byte[5:0];
          hdr_pending_r <= 1'b1;
        end
      end else begin
        hdr_pending_r <= 1'b0;
      end
      if (cap) begin
        base_valid_r[ax_idx] <= 1'b1;
      end
    end
  end

  // Baseline memory. Two data words of one channel are always parted by a
  // header word, so a capture is written back well before the next read of it.
  always_ff @(posedge clk) begin
    if (cap) begin
      base_mem[ax_idx] <= reading;
    end
    if (ana) begin
      base_rd_r <= base_mem[ax_idx];
    end
  end

  // First stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r  <= s0_tag;
    s1_read_r <= reading;
  end

  // Offset from the baseline as sign and magnitude. A baseline capture or a button
  // word reports a value of zero.
  always_comb begin
    diff   = {1'b0, s1_read_r} - {1'b0, base_rd_r};
    s1_neg = diff[jpd_pkg::READ_W];
    s1_mag = s1_neg ? jpd_pkg::READ_W'((~diff) + 1'b1) : diff[jpd_pkg::READ_W-1:0];
    if (s1_tag_r.kind != jpd_pkg::KIND_ANALOG) begin
      s1_mag = '0;
      s1_neg = 1'b0;
    end
  end

  jpd_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (s1_v_r),
    .in_tag  (s1_tag_r),
    .in_mag  (s1_mag),
    .in_neg  (s1_neg),
    .out_v   (sc_v),
    .out_res (sc_res),
    .busy    (sc_busy)
  );

  // Result queue.
  assign push = sc_v;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= sc_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + CW'(push) - CW'(pop);
    end
  end

  // Output word from the queue head.
  assign head             = fifo_mem[rd_ptr_r];
  assign out_valid        = (fifo_cnt_r != '0);
  assign out_chan_index   = head.tag.chan;
  assign out_report_kind  = head.tag.kind;
  assign out_axis_value   = head.value;
  assign out_left_button  = head.tag.left;
  assign out_right_button = head.tag.right;

  // The queue never takes a word when full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> fifo_cnt_r != CW'(jpd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // Reserved slots never exceed the queue depth.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= CW'(jpd_pkg::FIFO_DEPTH))
    else $error("in-flight words exceed queue room");

  // Button words come only from the button channel.
  a_btn_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_kind == jpd_pkg::KIND_BUTTONS |-> out_chan_index == jpd_pkg::BTN_CHAN)
    else $error("button word on an analogue channel");

  // Axis values stay within plus or minus one half.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_axis_value <= 16'sd16384) && (out_axis_value >= -16'sd16384))
    else $error("axis value outside clamp range");

endmodule
